>>> hdl/tspg_pkg.sv
// shared types, constants and helper function of the torus point generator
package tspg_pkg;

   localparam int NUM_W     = 42;
   localparam int DIV_STEPS = NUM_W;
   localparam int REM_W     = 9;
   localparam int Q_W       = 32;
   localparam int CW        = 33;
   localparam int ATAN_LEN  = 24;

   localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   localparam int CSR_MINOR  = 0;
   localparam int CSR_MAJOR  = 1;
   localparam int CSR_TUBE   = 2;
   localparam int CSR_AROUND = 3;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [REM_W-1:0] rem;
      logic [Q_W-1:0]   quo;
   } div_lane_type;

   typedef struct packed {
      logic         valid;
      logic         last;
      div_lane_type th;
      div_lane_type ph;
   } div_type;

   typedef struct packed {
      logic [1:0]           quarter;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } rot_lane_type;

   typedef struct packed {
      logic         valid;
      logic         last;
      rot_lane_type th;
      rot_lane_type ph;
   } cordic_type;

   function automatic logic [19:0] sat20(input logic signed [23:0] v);
      logic [19:0] r;
      if (v > 24'sd524287) begin
         r = 20'h7FFFF;
      end else if (v < -24'sd524288) begin
         r = 20'h80000;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/torus_surface_point_generator.sv
// top level of the torus surface point generator
// Each accepted grid cell (ring index, around index) yields two points, the
// k=0 point then the k=1 point flagged by rsp_tlast. Points leave one per
// cycle while the consumer is ready, and a new cell is taken when the front
// register is empty or issues the second point of the cell before it. A
// point passes a front register, a row of 42 restoring divider cells that
// form both phase angles, CORDIC_STAGES cordic cells and four scaling
// stages. The whole row moves together and halts only while a point waits
// in the output register.
module torus_surface_point_generator #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ring_index[7:0], around_index[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pos_x[19:0], pos_y[39:20], pos_z[59:40], zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   logic [14:0] minor_ff, major_ff;
   logic [7:0]  tube_ff, around_seg_ff;
   logic        adv;
   logic        f_valid_ff, f_k_ff;
   logic [7:0]  f_ring_ff, f_around_ff;
   logic [7:0]  tseg, aseg;
   logic [8:0]  n_sum;
   logic [tspg_pkg::REM_W-1:0] den_th, den_ph;
   logic [19:0] px, py, pz;

   tspg_pkg::div_type    div_chain [tspg_pkg::DIV_STEPS+1];
   tspg_pkg::cordic_type rot_chain [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         minor_ff      <= 15'd3277;
         major_ff      <= 15'd8192;
         tube_ff       <= 8'd50;
         around_seg_ff <= 8'd20;
      end else if (csr_we) begin
         unique case (csr_index)
            2'(tspg_pkg::CSR_MINOR):  minor_ff      <= csr_wdata;
            2'(tspg_pkg::CSR_MAJOR):  major_ff      <= csr_wdata;
            2'(tspg_pkg::CSR_TUBE):   tube_ff       <= csr_wdata[7:0];
            2'(tspg_pkg::CSR_AROUND): around_seg_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = !f_valid_ff || (adv && f_k_ff);

   // each cell is issued twice, once per point
   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         f_k_ff     <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         f_valid_ff <= 1'b1;
         f_k_ff     <= 1'b0;
      end else if (adv && f_valid_ff) begin
         if (f_k_ff) begin
            f_valid_ff <= 1'b0;
         end else begin
            f_k_ff <= 1'b1;
         end
      end
      if (req_tvalid && req_tready) begin
         f_ring_ff   <= req_tdata[7:0];
         f_around_ff <= req_tdata[15:8];
      end
   end

   assign tseg   = (tube_ff == 8'd0) ? 8'd1 : tube_ff;
   assign aseg   = (around_seg_ff == 8'd0) ? 8'd1 : around_seg_ff;
   assign den_th = {aseg, 1'b0};
   assign den_ph = {tseg, 1'b0};
   assign n_sum  = {1'b0, f_ring_ff} + {8'd0, f_k_ff};

   // numerators: (2j << 32) + A and ((2n+1) << 32) + T, low 32 quotient bits kept
   always_comb begin
      div_chain[0].valid  = f_valid_ff;
      div_chain[0].last   = f_k_ff;
      div_chain[0].th.num = {1'b0, f_around_ff, 1'b0, 24'd0, aseg};
      div_chain[0].th.rem = '0;
      div_chain[0].th.quo = '0;
      div_chain[0].ph.num = {n_sum, 1'b1, 24'd0, tseg};
      div_chain[0].ph.rem = '0;
      div_chain[0].ph.quo = '0;
   end

   for (genvar i = 0; i < tspg_pkg::DIV_STEPS; i++) begin : g_div
      tspg_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .den_th   (den_th),
         .den_ph   (den_ph),
         .cell_in  (div_chain[i]),
         .cell_out (div_chain[i+1])
      );
   end

   always_comb begin
      rot_chain[0].valid      = div_chain[tspg_pkg::DIV_STEPS].valid;
      rot_chain[0].last       = div_chain[tspg_pkg::DIV_STEPS].last;
      rot_chain[0].th.quarter = div_chain[tspg_pkg::DIV_STEPS].th.quo[31:30];
      rot_chain[0].th.x       = tspg_pkg::GAIN_Q30;
      rot_chain[0].th.y       = '0;
      rot_chain[0].th.z       = {3'b0, div_chain[tspg_pkg::DIV_STEPS].th.quo[29:0]};
      rot_chain[0].ph.quarter = div_chain[tspg_pkg::DIV_STEPS].ph.quo[31:30];
      rot_chain[0].ph.x       = tspg_pkg::GAIN_Q30;
      rot_chain[0].ph.y       = '0;
      rot_chain[0].ph.z       = {3'b0, div_chain[tspg_pkg::DIV_STEPS].ph.quo[29:0]};
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      tspg_cordic_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_in  (rot_chain[i]),
         .cell_out (rot_chain[i+1])
      );
   end

   tspg_post u_post (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .rot_in       (rot_chain[CORDIC_STAGES]),
      .minor_radius (minor_ff),
      .major_radius (major_ff),
      .out_valid    (rsp_tvalid),
      .out_last     (rsp_tlast),
      .out_x        (px),
      .out_y        (py),
      .out_z        (pz)
   );

   assign rsp_tdata = {4'b0, pz, py, px};

endmodule

>>> hdl/tspg_div_cell.sv
// one restoring division step for the around and tube phase lanes
module tspg_div_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [tspg_pkg::REM_W-1:0] den_th,
   input  logic [tspg_pkg::REM_W-1:0] den_ph,
   input  tspg_pkg::div_type          cell_in,
   output tspg_pkg::div_type          cell_out
);

   tspg_pkg::div_type stage_ff;
   tspg_pkg::div_type stage_in;

   function automatic tspg_pkg::div_lane_type div_step(input tspg_pkg::div_lane_type l,
                                                      input logic [tspg_pkg::REM_W-1:0] d);
      tspg_pkg::div_lane_type r;
      logic [tspg_pkg::REM_W:0] trial;
      logic                     ge;
      trial = {l.rem, l.num[tspg_pkg::NUM_W-1]};
      ge    = trial >= {1'b0, d};
      r.num = {l.num[tspg_pkg::NUM_W-2:0], 1'b0};
      r.rem = ge ? tspg_pkg::REM_W'(trial - {1'b0, d}) : trial[tspg_pkg::REM_W-1:0];
      r.quo = {l.quo[tspg_pkg::Q_W-2:0], ge};
      return r;
   endfunction

   always_comb begin
      stage_in.valid = cell_in.valid;
      stage_in.last  = cell_in.last;
      stage_in.th    = div_step(cell_in.th, den_th);
      stage_in.ph    = div_step(cell_in.ph, den_ph);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (adv) begin
         stage_ff.last <= stage_in.last;
         stage_ff.th   <= stage_in.th;
         stage_ff.ph   <= stage_in.ph;
      end
   end

   assign cell_out = stage_ff;

endmodule

>>> hdl/tspg_cordic_cell.sv
// one rotation-mode cordic step for both angle lanes
module tspg_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  tspg_pkg::cordic_type cell_in,
   output tspg_pkg::cordic_type cell_out
);

   localparam logic signed [tspg_pkg::CW-1:0] ATAN =
      $signed({1'b0, tspg_pkg::ATAN_TURNS[SHIFT]});

   tspg_pkg::cordic_type stage_ff;
   tspg_pkg::cordic_type stage_in;

   function automatic tspg_pkg::rot_lane_type rot_step(input tspg_pkg::rot_lane_type l);
      tspg_pkg::rot_lane_type r;
      logic signed [tspg_pkg::CW-1:0] dx;
      logic signed [tspg_pkg::CW-1:0] dy;
      dx        = l.y >>> SHIFT;
      dy        = l.x >>> SHIFT;
      r.quarter = l.quarter;
      if (!l.z[tspg_pkg::CW-1]) begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - ATAN;
      end else begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + ATAN;
      end
      return r;
   endfunction

   always_comb begin
      stage_in.valid = cell_in.valid;
      stage_in.last  = cell_in.last;
      stage_in.th    = rot_step(cell_in.th);
      stage_in.ph    = rot_step(cell_in.ph);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (adv) begin
         stage_ff.last <= stage_in.last;
         stage_ff.th   <= stage_in.th;
         stage_ff.ph   <= stage_in.ph;
      end
   end

   assign cell_out = stage_ff;

endmodule

>>> hdl/tspg_post.sv
// quadrant fold, radius scaling, rounding, saturation and output register
module tspg_post (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  tspg_pkg::cordic_type rot_in,
   input  logic [14:0]          minor_radius,
   input  logic [14:0]          major_radius,
   output logic                 out_valid,
   output logic                 out_last,
   output logic [19:0]          out_x,
   output logic [19:0]          out_y,
   output logic [19:0]          out_z
);

   logic signed [31:0] ct, st, cp, sp;
   logic signed [47:0] rprod_c, rprod_s;
   logic signed [51:0] rimf_in;

   logic               v1_ff, v2_ff, v3_ff, vo_ff;
   logic               l1_ff, l2_ff, l3_ff, lo_ff;
   logic signed [51:0] rimf_ff;
   logic signed [47:0] zp1_ff, zp2_ff, zp3_ff;
   logic signed [31:0] ct1_ff, st1_ff, ct2_ff, st2_ff;
   logic signed [33:0] rim2_ff;
   logic signed [65:0] px3_ff, py3_ff;
   logic [19:0]        x_ff, y_ff, z_ff;

   logic signed [51:0] rsum;
   logic signed [65:0] sx, sy;
   logic signed [47:0] sz;
   logic signed [33:0] rim_in;
   logic signed [65:0] px_in, py_in;

   function automatic logic [63:0] fold(input tspg_pkg::rot_lane_type l);
      logic signed [tspg_pkg::CW-1:0] nx, ny;
      logic signed [tspg_pkg::CW-1:0] co, si;
      nx = -l.x;
      ny = -l.y;
      case (l.quarter)
         2'd0:    begin co = l.x; si = l.y; end
         2'd1:    begin co = ny;  si = l.x; end
         2'd2:    begin co = nx;  si = ny;  end
         default: begin co = l.y; si = nx;  end
      endcase
      return {co[31:0], si[31:0]};
   endfunction

   always_comb begin
      {ct, st} = fold(rot_in.th);
      {cp, sp} = fold(rot_in.ph);
      rprod_c  = $signed({1'b0, minor_radius}) * cp;
      rprod_s  = $signed({1'b0, minor_radius}) * sp;
      rimf_in  = $signed({7'b0, major_radius, 30'b0}) + {{4{rprod_c[47]}}, rprod_c};
      rsum     = rimf_ff + 52'sd8192;
      rim_in   = rsum[47:14];
      px_in    = rim2_ff * ct2_ff;
      py_in    = rim2_ff * st2_ff;
      sx       = px3_ff + (66'sd1 <<< 42);
      sy       = py3_ff + (66'sd1 <<< 42);
      sz       = zp3_ff + (48'sd1 <<< 26);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= rot_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
      if (adv) begin
         l1_ff   <= rot_in.last;
         rimf_ff <= rimf_in;
         zp1_ff  <= rprod_s;
         ct1_ff  <= ct;
         st1_ff  <= st;
         l2_ff   <= l1_ff;
         rim2_ff <= rim_in;
         zp2_ff  <= zp1_ff;
         ct2_ff  <= ct1_ff;
         st2_ff  <= st1_ff;
         l3_ff   <= l2_ff;
         px3_ff  <= px_in;
         py3_ff  <= py_in;
         zp3_ff  <= zp2_ff;
         lo_ff   <= l3_ff;
         x_ff    <= tspg_pkg::sat20({sx[65], sx[65:43]});
         y_ff    <= tspg_pkg::sat20({sy[65], sy[65:43]});
         z_ff    <= tspg_pkg::sat20({{3{sz[47]}}, sz[47:27]});
      end
   end

   assign out_valid = vo_ff;
   assign out_last  = lo_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

>>> hdl/tspg_checker.sv
// port-level checks of the torus point generator, bound to the top level
module tspg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic [15:0] pend_ff;
   logic        want_last_ff;
   logic        in_xact, out_xact;

   assign in_xact  = req_tvalid && req_tready;
   assign out_xact = rsp_tvalid && rsp_tready;

   // points still owed to the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         want_last_ff <= 1'b0;
      end else begin
         pend_ff <= pend_ff + (in_xact ? 16'd2 : 16'd0) - (out_xact ? 16'd1 : 16'd0);
         if (out_xact) begin
            want_last_ff <= !want_last_ff;
         end
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 16'd0)
      else $error("result without a pending cell");

   a_last_order: assert property (@(posedge clock) disable iff (reset)
      out_xact |-> rsp_tlast == want_last_ff)
      else $error("points of a cell out of order");

endmodule

bind torus_surface_point_generator tspg_checker u_tspg_checker (.*);

>>> tb/tb_top.sv
// self-checking testbench of the torus surface point generator
`timescale 1ns / 100ps

module tb_top;

   localparam int  NUM_PHASES  = 9;
   localparam int  PHASE_ITEMS = 184;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  HOLD_CYCLES = 400;
   localparam int  TRAIL       = 120;

   typedef struct {
      logic [19:0] x;
      logic [19:0] y;
      logic [19:0] z;
      logic        last;
   } point_type;

   typedef struct {
      logic [7:0] ring;
      logic [7:0] around;
      bit         typed;   // expectation written in the table: all coordinates zero
   } cell_type;

   typedef struct {
      int         cfg_set;
      logic [7:0] ring;
      logic [7:0] around;
      bit         typed;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   logic [14:0] minor_r  = 15'd3277;
   logic [14:0] major_r  = 15'd8192;
   logic [7:0]  tube_seg = 8'd50;
   logic [7:0]  arnd_seg = 8'd20;

   point_type pending_points[$];
   cell_type  offered_cells[$];
   int     errors = 0;
   int     cycles = 0;
   int     points_seen = 0;
   int     tx_idle_pct = 0;
   int     rx_idle_pct = 0;
   bit     hold_req = 1'b0;
   logic   hold_rx = 1'b0;

   torus_surface_point_generator dut (.*);

   always #2 clock = ~clock;

   // rotation-mode cordic on a phase in 2^-32 turns, results in Q2.30
   function automatic void cordic_sincos(input logic [31:0] phase,
                                         output longint co, output longint si);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = longint'(phase[29:0]);
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(tspg_pkg::ATAN_TURNS[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(tspg_pkg::ATAN_TURNS[i]);
         end
      end
      case (phase[31:30])
         2'd0: begin co = x;  si = y;  end
         2'd1: begin co = -y; si = x;  end
         2'd2: begin co = -x; si = -y; end
         default: begin co = y; si = -x; end
      endcase
   endfunction

   function automatic longint round_sh(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic [19:0] clamp20(input longint v);
      if (v > 524287) return 20'h7FFFF;
      if (v < -524288) return 20'h80000;
      return v[19:0];
   endfunction

   function automatic void torus_points(input logic [7:0] ring, input logic [7:0] around);
      longint unsigned tseg, aseg, m, num;
      logic [31:0] theta, phi;
      longint ct, st, cp, sp, rim;
      point_type p;
      tseg = (tube_seg == 0) ? 1 : tube_seg;
      aseg = (arnd_seg == 0) ? 1 : arnd_seg;
      num = ((2 * longint'(around)) << 32) + aseg;
      theta = 32'(num / (2 * aseg));
      cordic_sincos(theta, ct, st);
      for (int k = 0; k < 2; k++) begin
         m = (longint'(ring) + k) % tseg;
         num = ((2 * m + 1) << 32) + tseg;
         phi = 32'(num / (2 * tseg));
         cordic_sincos(phi, cp, sp);
         rim = (longint'(major_r) << 30) + longint'(minor_r) * cp;
         rim = round_sh(rim, 14);
         p.x = clamp20(round_sh(rim * ct, 43));
         p.y = clamp20(round_sh(rim * st, 43));
         p.z = clamp20(round_sh(longint'(minor_r) * sp, 27));
         p.last = (k == 1);
         pending_points.push_back(p);
      end
   endfunction

   task automatic report(input string field, input logic [19:0] got, input logic [19:0] want);
      $display("mismatch on %s at cycle %0d: got %h, expected %h", field, cycles, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[torus_surface_point_generator] ERROR");
         $finish;
      end
   end

   // receiver side ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // long receiver hold-off so the pipe backs up into the input
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rx <= 1'b0;
            hold_req = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      point_type p;
      cell_type  c;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            points_seen++;
            if (pending_points.size() == 0) begin
               $display("unexpected point at cycle %0d", cycles);
               errors++;
            end else begin
               p = pending_points.pop_front();
               if (rsp_tdata[19:0] !== p.x) report("pos_x", rsp_tdata[19:0], p.x);
               if (rsp_tdata[39:20] !== p.y) report("pos_y", rsp_tdata[39:20], p.y);
               if (rsp_tdata[59:40] !== p.z) report("pos_z", rsp_tdata[59:40], p.z);
               if (rsp_tlast !== p.last) report("last_point", 20'(rsp_tlast), 20'(p.last));
               if (rsp_tdata[63:60] !== 4'h0) report("pad", 20'(rsp_tdata[63:60]), 20'h0);
            end
         end
         if (req_tvalid && req_tready) begin
            c = offered_cells.pop_front();
            if (c.typed) begin
               for (int k = 0; k < 2; k++) begin
                  p.x = '0; p.y = '0; p.z = '0; p.last = (k == 1);
                  pending_points.push_back(p);
               end
            end else begin
               torus_points(c.ring, c.around);
            end
         end
      end
   end

   task automatic send_cell(input logic [7:0] ring, input logic [7:0] around, input bit typed);
      cell_type c;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      c.ring = ring; c.around = around; c.typed = typed;
      offered_cells.push_back(c);
      req_tvalid <= 1'b1;
      req_tdata  <= {around, ring};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0 || offered_cells.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input int idx, input logic [14:0] val);
      csr_we    <= 1'b1;
      csr_index <= 2'(idx);
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         tspg_pkg::CSR_MINOR:  minor_r  = val;
         tspg_pkg::CSR_MAJOR:  major_r  = val;
         tspg_pkg::CSR_TUBE:   tube_seg = val[7:0];
         tspg_pkg::CSR_AROUND: arnd_seg = val[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [14:0] mn, input logic [14:0] mj,
                            input logic [7:0] ts, input logic [7:0] as);
      drain();
      write_reg(tspg_pkg::CSR_MINOR, mn);
      write_reg(tspg_pkg::CSR_MAJOR, mj);
      write_reg(tspg_pkg::CSR_TUBE, {7'd0, ts});
      write_reg(tspg_pkg::CSR_AROUND, {7'd0, as});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   row_type rows[] = '{
      '{0, 8'd0,   8'd0,   0}, '{0, 8'd49,  8'd19,  0}, '{0, 8'd49,  8'd0,   0},
      '{0, 8'd254, 8'd254, 0}, '{0, 8'd255, 8'd255, 0}, '{0, 8'd0,   8'd255, 0},
      '{0, 8'd255, 8'd0,   0}, '{0, 8'd12,  8'd5,   0}, '{0, 8'd24,  8'd10,  0},
      '{0, 8'd37,  8'd15,  0}, '{0, 8'd50,  8'd20,  0},
      '{1, 8'd0,   8'd0,   1}, '{1, 8'd255, 8'd255, 1}, '{1, 8'd17,  8'd200, 1},
      '{2, 8'd0,   8'd0,   0}, '{2, 8'd127, 8'd63,  0}, '{2, 8'd254, 8'd254, 0},
      '{2, 8'd255, 8'd255, 0}, '{2, 8'd63,  8'd191, 0},
      '{3, 8'd0,   8'd0,   0}, '{3, 8'd5,   8'd9,   0}, '{3, 8'd255, 8'd128, 0}
   };

   task automatic apply_set(input int s);
      case (s)
         0: configure(15'd3277, 15'd8192, 8'd50, 8'd20);
         1: configure(15'd0, 15'd0, 8'd50, 8'd20);
         2: configure(15'h7FFF, 15'h7FFF, 8'd255, 8'd255);
         default: configure(15'd9000, 15'd12000, 8'd0, 8'd0);
      endcase
   endtask

   initial begin
      int cur_set;
      logic [7:0] ring, around, ts, as;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cells, first block runs on the reset settings
      cur_set = 0;
      for (int r = 0; r < rows.size(); r++) begin
         if (rows[r].cfg_set != cur_set) begin
            cur_set = rows[r].cfg_set;
            apply_set(cur_set);
         end
         send_cell(rows[r].ring, rows[r].around, rows[r].typed);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph % 5)
            0: configure(15'($urandom), 15'($urandom), 8'($urandom_range(255, 1)),
                         8'($urandom_range(255, 1)));
            1: configure(15'h7FFF, 15'h7FFF, 8'd255, 8'd255);
            2: configure(15'd0, 15'($urandom), 8'd1, 8'd1);
            3: configure(15'($urandom_range(4000)), 15'($urandom_range(16000)),
                         8'($urandom_range(16)), 8'($urandom_range(16)));
            default: configure(15'($urandom), 15'd0, 8'($urandom), 8'($urandom));
         endcase
         if (ph < 3) begin
            tx_idle_pct = 31; rx_idle_pct = 81;
         end else if (ph < 6) begin
            tx_idle_pct = 81; rx_idle_pct = 31;
         end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         if (ph == 6) hold_req = 1'b1;
         ts = (tube_seg == 0) ? 8'd1 : tube_seg;
         as = (arnd_seg == 0) ? 8'd1 : arnd_seg;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(9) < 8) begin
               ring   = 8'($urandom_range(ts - 1));
               around = 8'($urandom_range(as - 1));
            end else begin
               ring   = 8'($urandom);
               around = 8'($urandom);
            end
            send_cell(ring, around, 1'b0);
         end
      end

      drain();
      repeat (TRAIL) @(posedge clock);
      $display("checked %0d points from directed cells and %0d random phases of settings",
               points_seen, NUM_PHASES);
      $display("covered segment counts 0, 1 and 255, zero and full radii, long output stall");
      if (errors == 0) begin
         $display("[torus_surface_point_generator] OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("[torus_surface_point_generator] ERROR");
      end
      $finish;
   end

endmodule
